[src/assert_macros.svh]
// Assertion macros shared by the frame difference change rate modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDCR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("FDCR check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define FDCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("FDCR check failed: next-cycle implication");

`endif

[src/fdcr_pkg.sv]
// Types and constants shared by the frame difference change rate modules.
package fdcr_pkg;

	// Frame size limit and the counter cap that follows from it.
	localparam int unsigned MAX_FRAME_PIXELS = 4194304;
	localparam int unsigned COUNT_LIMIT      = 8388607;
	localparam int          COUNT_W          = 23;
	localparam logic [COUNT_W-1:0] COUNT_CAP =
		COUNT_W'((MAX_FRAME_PIXELS < COUNT_LIMIT) ? MAX_FRAME_PIXELS : COUNT_LIMIT);

	// Gray conversion weights (BT.601, scaled by 2^14) and rounding term.
	localparam int          GRAY_W     = 22;
	localparam logic [GRAY_W-1:0] W_RED      = 22'd4899;
	localparam logic [GRAY_W-1:0] W_GREEN    = 22'd9617;
	localparam logic [GRAY_W-1:0] W_BLUE     = 22'd1868;
	localparam logic [GRAY_W-1:0] GRAY_ROUND = 22'd8192;

	localparam logic [7:0] MASK_ON          = 8'd255;
	localparam logic [7:0] THRESHOLD_RESET  = 8'd25;

	// Share in hundredths of a percent: quotient below 2^14.
	localparam int          QUOT_BITS = 14;
	localparam logic [QUOT_BITS-1:0] PCT_SCALE = 14'd10000;
	localparam int          REM_W     = COUNT_W + QUOT_BITS;
	localparam int          DEN_W     = COUNT_W + QUOT_BITS - 1;
	localparam int          STEP_W    = $clog2(QUOT_BITS);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic frame_end;
		logic load_product;
		logic div_step;
	} fdcr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_last;
	} fdcr_status_t;

endpackage

[src/fdcr_ctrl.sv]
// Controller state machine: handshakes and sequencing of the end-of-frame division.
`include "assert_macros.svh"

module fdcr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tlast,
	output logic                 s_axis_tready,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output fdcr_pkg::fdcr_cmd_t  cmd,
	input  fdcr_pkg::fdcr_status_t status
);

	typedef enum logic [1:0] {
		ST_RUN,
		ST_PRODUCT,
		ST_DIVIDE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_fire;

	// Input is taken while running and the output register is free or being emptied.
	assign s_axis_tready = (state_q == ST_RUN) && (!out_valid_q || m_axis_tready);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;

	// Commands to the datapath.
	always_comb begin
		cmd              = '0;
		cmd.accept       = in_fire;
		cmd.frame_end    = in_fire && s_axis_tlast;
		cmd.load_product = (state_q == ST_PRODUCT);
		cmd.div_step     = (state_q == ST_DIVIDE);
	end

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (in_fire) begin
						out_valid_q <= !s_axis_tlast;
						if (s_axis_tlast) begin
							state_q <= ST_PRODUCT;
						end
					end else if (m_axis_tready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_PRODUCT: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (status.div_last) begin
						state_q     <= ST_RUN;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// The last pixel of a frame must not show a result before the division.
	`FDCR_ASSERT_NEXT(a_frame_end_waits, clk, arst_n, cmd.frame_end, !out_valid_q && state_q == ST_PRODUCT)
	// The final division step presents the result and returns to streaming.
	`FDCR_ASSERT_NEXT(a_div_finish, clk, arst_n, state_q == ST_DIVIDE && status.div_last, out_valid_q && state_q == ST_RUN)

endmodule

[src/fdcr_datapath.sv]
// Datapath: difference mask, frame counters and the iterative share divider.
`include "assert_macros.svh"

module fdcr_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [7:0]             cfg_wr_data,
	input  fdcr_pkg::fdcr_cmd_t    cmd,
	output fdcr_pkg::fdcr_status_t status,
	input  logic [47:0]            in_data,
	output logic [7:0]             mask_value,
	output logic [fdcr_pkg::COUNT_W-1:0]   changed_total,
	output logic [fdcr_pkg::QUOT_BITS-1:0] change_hundredths
);

	localparam int CW = fdcr_pkg::COUNT_W;
	localparam int QB = fdcr_pkg::QUOT_BITS;
	localparam int RW = fdcr_pkg::REM_W;
	localparam int DW = fdcr_pkg::DEN_W;
	localparam int SW = fdcr_pkg::STEP_W;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (v < fdcr_pkg::COUNT_CAP) ? (v + CW'(1)) : fdcr_pkg::COUNT_CAP;
	endfunction

	logic [7:0]          thr_q;
	logic [CW-1:0]       pix_q;
	logic [CW-1:0]       chg_q;
	logic                changed_q;
	logic [CW-1:0]       total_q;
	logic [CW-1:0]       divisor_q;
	logic [QB-1:0]       quot_q;
	logic [RW-1:0]       rem_q;
	logic [DW-1:0]       den_q;
	logic [SW-1:0]       step_q;

	logic [7:0]          diff_b;
	logic [7:0]          diff_g;
	logic [7:0]          diff_r;
	logic [fdcr_pkg::GRAY_W-1:0] gray_sum;
	logic [7:0]          gray;
	logic                changed;
	logic [CW-1:0]       pix_next;
	logic [CW-1:0]       chg_next;
	logic                rem_ge;

	// Per-channel absolute difference and weighted gray level.
	assign diff_b   = abs_diff(in_data[7:0],   in_data[31:24]);
	assign diff_g   = abs_diff(in_data[15:8],  in_data[39:32]);
	assign diff_r   = abs_diff(in_data[23:16], in_data[47:40]);
	assign gray_sum = {14'd0, diff_r} * fdcr_pkg::W_RED
	                + {14'd0, diff_g} * fdcr_pkg::W_GREEN
	                + {14'd0, diff_b} * fdcr_pkg::W_BLUE
	                + fdcr_pkg::GRAY_ROUND;
	assign gray     = gray_sum[21:14];
	assign changed  = gray > thr_q;

	// Saturating counter updates for the accepted pixel.
	assign pix_next = sat_inc(pix_q);
	assign chg_next = changed ? sat_inc(chg_q) : chg_q;

	// Restoring division, one quotient bit per step.
	assign rem_ge          = rem_q >= {1'b0, den_q};
	assign status.div_last = (step_q == '0);

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= fdcr_pkg::THRESHOLD_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// Frame counters, cleared after the last pixel of each frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
			chg_q <= '0;
		end else if (cmd.frame_end) begin
			pix_q <= '0;
			chg_q <= '0;
		end else if (cmd.accept) begin
			pix_q <= pix_next;
			chg_q <= chg_next;
		end
	end

	// Result register and divider state.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			changed_q <= changed;
			quot_q    <= '0;
			total_q   <= cmd.frame_end ? chg_next : '0;
			divisor_q <= pix_next;
		end
		if (cmd.load_product) begin
			rem_q  <= {{QB{1'b0}}, total_q} * {{CW{1'b0}}, fdcr_pkg::PCT_SCALE};
			den_q  <= {divisor_q, {(QB-1){1'b0}}};
			step_q <= SW'(QB - 1);
		end
		if (cmd.div_step) begin
			if (rem_ge) begin
				rem_q <= rem_q - {1'b0, den_q};
			end
			quot_q <= {quot_q[QB-2:0], rem_ge};
			den_q  <= den_q >> 1;
			step_q <= step_q - SW'(1);
		end
	end

	assign mask_value        = changed_q ? fdcr_pkg::MASK_ON : 8'd0;
	assign changed_total     = total_q;
	assign change_hundredths = quot_q;

	// Both counters saturate at the same cap, so changed never passes total.
	`FDCR_ASSERT_IMPL(a_chg_le_pix, clk, arst_n, 1'b1, chg_q <= pix_q)

endmodule

[src/frame_difference_change_rate_top.sv]
// Top level of the frame difference change rate block.
//
//  Channel   Direction  Transaction content
//  s_axis    in         one co-located pixel pair of previous and current frame
//  m_axis    out        mask pixel, with frame totals on the last pixel
//  cfg       in         write of the difference threshold
//
// One pixel per clock is sustained for pixels that do not end a frame, while the output is not stalled.
// The last pixel of a frame goes through acceptance, a product state that forms changed*10000
// and the restoring divider, which yields the 14 quotient bits, one quotient bit per cycle.
// Reset is asynchronous and active low; it clears the counters and sets the threshold to 25.
// A stalled output holds its transaction; input is taken as soon as the output register frees.
`include "assert_macros.svh"

module frame_difference_change_rate_top (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] prev_blue, [15:8] prev_green, [23:16] prev_red,
	// [31:24] curr_blue, [39:32] curr_green, [47:40] curr_red
	input  logic [47:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	// Output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] mask_value, [30:8] changed_total, [44:31] change_hundredths, [47:45] zero
	output logic [47:0] m_axis_tdata,
	output logic        m_axis_tlast,
	// Configuration
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);

	fdcr_pkg::fdcr_cmd_t    cmd;
	fdcr_pkg::fdcr_status_t status;
	logic [7:0]                           mask_value;
	logic [fdcr_pkg::COUNT_W-1:0]         changed_total;
	logic [fdcr_pkg::QUOT_BITS-1:0]       change_hundredths;
	logic                                 frame_done_q;

	// Controller.
	fdcr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cmd           (cmd),
		.status        (status)
	);

	// Datapath.
	fdcr_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.cmd               (cmd),
		.status            (status),
		.in_data           (s_axis_tdata),
		.mask_value        (mask_value),
		.changed_total     (changed_total),
		.change_hundredths (change_hundredths)
	);

	// End-of-frame flag travels with the result transaction.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			frame_done_q <= s_axis_tlast;
		end
	end

	assign m_axis_tlast = frame_done_q;
	assign m_axis_tdata = {3'd0, change_hundredths, changed_total, mask_value};

	// A reported share never exceeds one hundred percent.
	`FDCR_ASSERT_IMPL(a_share_range, clk, arst_n, m_axis_tvalid && m_axis_tlast, change_hundredths <= fdcr_pkg::PCT_SCALE)
	// Results that do not end a frame carry no totals.
	`FDCR_ASSERT_IMPL(a_no_totals_midframe, clk, arst_n, m_axis_tvalid && !m_axis_tlast, changed_total == '0 && change_hundredths == '0)

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the frame difference change rate block.
`timescale 1ns / 100ps

module tb_top;

	// Result of one pixel transaction, as the block should produce it.
	typedef struct packed {
		logic [7:0]                 mask;
		logic                       done;
		logic [fdcr_pkg::COUNT_W-1:0] changed_total;
		logic [13:0]                hundredths;
	} pixel_result_t;

	// One pixel pair; rows with typed set carry their result written out by hand.
	typedef struct packed {
		logic [7:0]    prev_blue;
		logic [7:0]    prev_green;
		logic [7:0]    prev_red;
		logic [7:0]    curr_blue;
		logic [7:0]    curr_green;
		logic [7:0]    curr_red;
		logic          end_of_frame;
		logic          typed;
		pixel_result_t typed_result;
	} pixel_row_t;

	localparam int DIRECTED_ROWS = 15;
	localparam int SETTLE_CYCLES = 24;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_PIXELS  = 65;

	// Directed rows, all run at the reset threshold of 25.
	localparam pixel_row_t DIRECTED [DIRECTED_ROWS] = '{
		// Black on black, frame continues.
		'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, '{8'd0, 1'b0, 23'd0, 14'd0}},
		// Full-scale rise on every channel ends a two-pixel frame: half changed.
		'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1,
			'{8'd255, 1'b1, 23'd1, 14'd5000}},
		// Full-scale fall as a one-pixel frame: all changed.
		'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1,
			'{8'd255, 1'b1, 23'd1, 14'd10000}},
		// Identical pixels as a one-pixel frame: nothing changed.
		'{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 1'b1, 1'b1,
			'{8'd0, 1'b1, 23'd0, 14'd0}},
		// Green difference giving a gray level equal to the threshold.
		'{8'd0, 8'd0, 8'd0, 8'd0, 8'd43, 8'd0, 1'b0, 1'b0, '0},
		// Green difference giving one level above the threshold, falling.
		'{8'd0, 8'd100, 8'd0, 8'd0, 8'd56, 8'd0, 1'b0, 1'b0, '0},
		// Blue alone at full scale.
		'{8'd255, 8'd9, 8'd9, 8'd0, 8'd9, 8'd9, 1'b0, 1'b0, '0},
		// Red alone at full scale, ends the frame.
		'{8'd3, 8'd3, 8'd0, 8'd3, 8'd3, 8'd255, 1'b1, 1'b0, '0},
		// Channels moving in opposite directions.
		'{8'd200, 8'd10, 8'd77, 8'd10, 8'd200, 8'd77, 1'b0, 1'b0, '0},
		// Equal differences of 25 on all channels: gray exactly at the threshold.
		'{8'd50, 8'd50, 8'd50, 8'd75, 8'd25, 8'd75, 1'b0, 1'b0, '0},
		// Equal differences of 26: just over, ends the frame.
		'{8'd26, 8'd90, 8'd0, 8'd0, 8'd64, 8'd26, 1'b1, 1'b0, '0},
		// Three-pixel frame with one change: share truncates to 3333.
		'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1,
			'{8'd255, 1'b0, 23'd0, 14'd0}},
		'{8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 1'b0, 1'b1, '{8'd0, 1'b0, 23'd0, 14'd0}},
		'{8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 1'b1, 1'b1,
			'{8'd0, 1'b1, 23'd1, 14'd3333}},
		// White on white as a one-pixel frame.
		'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1,
			'{8'd0, 1'b1, 23'd0, 14'd0}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = '0;

	// Own copy of the block state and the threshold register.
	logic [7:0]                   model_threshold = fdcr_pkg::THRESHOLD_RESET;
	logic [fdcr_pkg::COUNT_W-1:0] model_changed = '0;
	logic [fdcr_pkg::COUNT_W-1:0] model_pixels = '0;

	pixel_result_t awaited_masks[$];
	int            mismatches = 0;
	int            results_seen = 0;
	int            pixels_sent = 0;
	int            frames_sent = 0;
	int            thresholds_used = 1;
	int            cycle_count = 0;
	int            stall_left = 0;
	bit            no_gaps = 1'b0;

	frame_difference_change_rate_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always #2 clk = ~clk;

	// Absolute difference of two channel values.
	function automatic int unsigned channel_diff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? int'(a - b) : int'(b - a);
	endfunction

	// Predicts the mask pixel and frame totals, advancing the counters.
	function automatic pixel_result_t difference_mask(input pixel_row_t px);
		int unsigned    gray;
		logic           changed;
		longint unsigned share;
		pixel_result_t  res;
		gray = (32'(fdcr_pkg::W_RED) * channel_diff(px.prev_red, px.curr_red)
			+ 32'(fdcr_pkg::W_GREEN) * channel_diff(px.prev_green, px.curr_green)
			+ 32'(fdcr_pkg::W_BLUE) * channel_diff(px.prev_blue, px.curr_blue)
			+ 32'(fdcr_pkg::GRAY_ROUND)) >> 14;
		changed = gray > model_threshold;
		if (model_pixels < fdcr_pkg::COUNT_CAP)
			model_pixels = model_pixels + fdcr_pkg::COUNT_W'(1);
		if (changed && model_changed < fdcr_pkg::COUNT_CAP)
			model_changed = model_changed + fdcr_pkg::COUNT_W'(1);
		res = '0;
		res.mask = changed ? fdcr_pkg::MASK_ON : 8'd0;
		res.done = px.end_of_frame;
		if (px.end_of_frame) begin
			share = (64'(model_changed) * 64'd10000) / 64'(model_pixels);
			res.changed_total = model_changed;
			res.hundredths = share[13:0];
			model_changed = '0;
			model_pixels = '0;
		end
		return res;
	endfunction

	// Idle length for either side: mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int roll;
		if (no_gaps) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Channel pair {prev, curr} whose absolute difference is d, direction random.
	function automatic logic [15:0] pair_with_diff(input int d);
		logic [7:0] base;
		if (d < 0) d = 0;
		if (d > 255) d = 255;
		base = 8'($urandom_range(0, 255 - d));
		if ($urandom_range(0, 1) == 1) return {base, 8'(base + d)};
		return {8'(base + d), base};
	endfunction

	// Random pixel pair: noise, near-threshold, unchanged or full contrast.
	function automatic pixel_row_t random_pixel(input logic last);
		pixel_row_t px;
		int         roll;
		int         d;
		logic [15:0] pb, pg, pr;
		px = '0;
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			{px.prev_blue, px.prev_green, px.prev_red} = 24'($urandom);
			{px.curr_blue, px.curr_green, px.curr_red} = 24'($urandom);
		end else if (roll < 75) begin
			d = int'(model_threshold) + $urandom_range(0, 2) - 1;
			pb = pair_with_diff(d + $urandom_range(0, 2) - 1);
			pg = pair_with_diff(d + $urandom_range(0, 2) - 1);
			pr = pair_with_diff(d + $urandom_range(0, 2) - 1);
			{px.prev_blue, px.curr_blue} = pb;
			{px.prev_green, px.curr_green} = pg;
			{px.prev_red, px.curr_red} = pr;
		end else if (roll < 90) begin
			{px.prev_blue, px.prev_green, px.prev_red} = 24'($urandom);
			{px.curr_blue, px.curr_green, px.curr_red} =
				{px.prev_blue, px.prev_green, px.prev_red};
		end else begin
			{px.prev_blue, px.prev_green, px.prev_red} = {24{1'($urandom_range(0, 1))}};
			{px.curr_blue, px.curr_green, px.curr_red} = ~{px.prev_blue, px.prev_green, px.prev_red};
		end
		px.end_of_frame = last;
		return px;
	endfunction

	// Presents one pixel after a random gap and records its result once accepted.
	// Called and returning at a rising edge.
	task automatic send_pixel(input pixel_row_t px);
		int            gap;
		pixel_result_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {px.curr_red, px.curr_green, px.curr_blue,
			px.prev_red, px.prev_green, px.prev_blue};
		s_axis_tlast  <= px.end_of_frame;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predicted = difference_mask(px);
		awaited_masks.push_back(px.typed ? px.typed_result : predicted);
		pixels_sent++;
		if (px.end_of_frame) frames_sent++;
	endtask

	// Lets every outstanding result arrive, then gives the block time to settle.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (awaited_masks.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [7:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_threshold = value;
		thresholds_used++;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("Mismatch at cycle %0d, result %0d: %s is %0d, expected %0d",
			cycle_count, results_seen, what, got, want);
		mismatches++;
	endtask

	// Output side: random back-pressure.
	always @(posedge clk) begin
		if (stall_left == 0) stall_left = pick_gap();
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Compare every output transaction with the oldest awaited result.
	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (awaited_masks.size() == 0) begin
				report_mismatch("result with nothing awaited, mask", m_axis_tdata[7:0], 0);
			end else begin
				want = awaited_masks.pop_front();
				if (m_axis_tdata[7:0] !== want.mask)
					report_mismatch("mask_value", m_axis_tdata[7:0], want.mask);
				if (m_axis_tlast !== want.done)
					report_mismatch("frame_done", m_axis_tlast, want.done);
				if (m_axis_tdata[30:8] !== want.changed_total)
					report_mismatch("changed_total", m_axis_tdata[30:8], want.changed_total);
				if (m_axis_tdata[44:31] !== want.hundredths)
					report_mismatch("change_hundredths", m_axis_tdata[44:31], want.hundredths);
				if (m_axis_tdata[47:45] !== 3'b000)
					report_mismatch("padding bits", m_axis_tdata[47:45], 0);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, awaited_masks.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stimulus: directed rows at the reset threshold, then random frames per threshold.
	initial begin
		logic [7:0] phase_threshold [RANDOM_PHASES];
		int         phase_count;
		int         frame_len;
		phase_threshold = '{8'd0, 8'd255, 8'($urandom), 8'd1, 8'd254, 8'($urandom)};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) send_pixel(DIRECTED[i]);
		drain_results();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_threshold(phase_threshold[p]);
			no_gaps = (p == 3);
			phase_count = 0;
			while (phase_count < PHASE_PIXELS) begin
				frame_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
					: $urandom_range(9, 40);
				for (int k = 0; k < frame_len; k++)
					send_pixel(random_pixel(k == frame_len - 1));
				phase_count += frame_len;
			end
			no_gaps = 1'b0;
			drain_results();
		end

		$display("Sent %0d pixels in %0d frames under %0d threshold settings, 0 and 255 among them.",
			pixels_sent, frames_sent, thresholds_used);
		$display("Compared %0d results; %0d mismatches found.", results_seen, mismatches);
		if (mismatches == 0 && awaited_masks.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
